>>> rtl/core/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

   localparam int ADDR_W           = 32;
   localparam int BYTE_COUNT_W     = 32;
   localparam int PAGE_COUNT_W     = 20;
   localparam int PAGE_SHIFT       = 12;
   localparam int FREE_STACK_DEPTH = 1024;
   localparam int WORD_ALIGN       = 4;

   localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
   localparam int STACK_AW   = (FREE_STACK_DEPTH > 1) ? $clog2(FREE_STACK_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(FREE_STACK_DEPTH + 1);

   // Length of a grant in bytes and the width that holds pointer plus length.
   localparam int LEN_W = (PAGE_COUNT_W + PAGE_SHIFT > ADDR_W) ?
                          (PAGE_COUNT_W + PAGE_SHIFT) : ADDR_W;
   localparam int SUM_W = LEN_W + 1;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'h0100_0000;

   typedef enum logic [1:0] {
      OP_BYTE_ALLOC = 2'd0,
      OP_PAGE_RUN   = 2'd1,
      OP_FREE_PAGE  = 2'd2,
      OP_ALLOC_PAGE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NULL       = 2'd1,
      ST_EXHAUSTED  = 2'd2,
      ST_STACK_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  rd;
      logic                  push;
      logic                  pop;
      logic [PAGE_NUM_W-1:0] push_page;
   } stack_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_status_type;

endpackage

>>> rtl/core/bpfa_req_if.sv
`timescale 1ns / 1ps

interface bpfa_req_if import bpfa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic [BYTE_COUNT_W-1:0] byte_count;
   logic [PAGE_COUNT_W-1:0] page_count;
   logic [ADDR_W-1:0]       freed_address;

   modport source (output valid, operation, byte_count, page_count, freed_address,
                   input ready);
   modport sink   (input valid, operation, byte_count, page_count, freed_address,
                   output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] granted_address;
   logic [1:0]        status;

   modport source (output valid, granted_address, status, input ready);
   modport sink   (input valid, granted_address, status, output ready);
endinterface

>>> rtl/core/bpfa_ram.sv
`timescale 1ns / 1ps

module bpfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bpfa_free_stack.sv
`timescale 1ns / 1ps

module bpfa_free_stack import bpfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  stack_ctrl_type        ctrl,
   output stack_status_type      stat,
   output logic [PAGE_NUM_W-1:0] top_page
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_m1;

   assign count_m1   = count_ff - COUNT_W'(1);
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == COUNT_W'(FREE_STACK_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The read addresses the current top entry; the data is registered and arrives in the next cycle.
   bpfa_ram #(
      .WIDTH (PAGE_NUM_W),
      .DEPTH (FREE_STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (count_ff[STACK_AW-1:0]),
      .wr_data (ctrl.push_page),
      .rd_en   (ctrl.rd),
      .rd_addr (count_m1[STACK_AW-1:0]),
      .rd_data (top_page)
   );

endmodule

>>> rtl/core/bump_and_free_page_allocator.sv
`timescale 1ns / 1ps

// Channel   Role     Handshake       Payload
// req_*     sink     valid / ready   operation, byte_count, page_count, freed_address
// rsp_*     source   valid / ready   granted_address, status
// csr_*     write    write_enable    write_data (heap base, loads the bump pointer)
//
// Each item passes through the states accept, align and stack read, then finish.
// The steps follow from the registered read of the free stack memory
// and the two pointer additions, which sit in separate states.
// Reset is synchronous and needs no clearing pass; the stack count starts at zero.
// The result sits in an output register, so a new item is taken in the cycle
// that the previous result leaves.

module bump_and_free_page_allocator import bpfa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bpfa_req_if.sink          req_channel,
   bpfa_rsp_if.source        rsp_channel,
   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_write_data
);

   localparam logic [SUM_W-1:0] WORD_MASK = SUM_W'(WORD_ALIGN - 1);
   localparam logic [SUM_W-1:0] PAGE_MASK = (SUM_W'(1) << PAGE_SHIFT) - SUM_W'(1);

   state_type state_ff, state_in;

   op_type                  op_ff, op_in;
   logic [BYTE_COUNT_W-1:0] bytes_ff, bytes_in;
   logic [PAGE_COUNT_W-1:0] pages_ff, pages_in;
   logic [PAGE_NUM_W-1:0]   freed_ff, freed_in;

   logic [SUM_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             null_ff, null_in;
   logic             use_stack_ff, use_stack_in;

   logic [ADDR_W-1:0] bp_ff, bp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   stack_ctrl_type        stack_ctrl;
   stack_status_type      stack_stat;
   logic [PAGE_NUM_W-1:0] top_page;

   logic             req_accept;
   logic [SUM_W-1:0] end_addr;
   logic [SUM_W-1:0] mask;
   logic             exhausted;

   assign req_channel.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_channel.ready);
   assign req_accept        = req_channel.valid && req_channel.ready;

   assign end_addr  = start_ff + SUM_W'(len_ff);
   assign exhausted = |end_addr[SUM_W-1:ADDR_W];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bytes_in      = bytes_ff;
      pages_in      = pages_ff;
      freed_in      = freed_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      null_in       = null_ff;
      use_stack_in  = use_stack_ff;
      bp_in         = bp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mask          = PAGE_MASK;

      stack_ctrl           = '0;
      stack_ctrl.push_page = freed_ff;

      if (rsp_valid_ff && rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = op_type'(req_channel.operation);
               bytes_in = req_channel.byte_count;
               pages_in = req_channel.page_count;
               freed_in = req_channel.freed_address[ADDR_W-1:PAGE_SHIFT];
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            // Round the pointer up and work out the length of the grant.
            mask         = (op_ff == OP_BYTE_ALLOC) ? WORD_MASK : PAGE_MASK;
            start_in     = (SUM_W'(bp_ff) + mask) & ~mask;
            use_stack_in = (op_ff == OP_ALLOC_PAGE) && !stack_stat.empty;
            stack_ctrl.rd = (op_ff == OP_ALLOC_PAGE) && !stack_stat.empty;
            unique case (op_ff)
               OP_BYTE_ALLOC: begin
                  len_in  = LEN_W'(bytes_ff);
                  null_in = (bytes_ff == '0);
               end
               OP_PAGE_RUN: begin
                  len_in  = LEN_W'(pages_ff) << PAGE_SHIFT;
                  null_in = (pages_ff == '0);
               end
               default: begin
                  len_in  = LEN_W'(1) << PAGE_SHIFT;
                  null_in = 1'b0;
               end
            endcase
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = '0;
            if (op_ff == OP_FREE_PAGE) begin
               if (stack_stat.full) begin
                  rsp_status_in = ST_STACK_FULL;
               end else begin
                  stack_ctrl.push = 1'b1;
                  rsp_status_in   = ST_OK;
               end
            end else if (use_stack_ff) begin
               stack_ctrl.pop = 1'b1;
               rsp_addr_in    = {top_page, {PAGE_SHIFT{1'b0}}};
               rsp_status_in  = ST_OK;
            end else if (null_ff) begin
               rsp_status_in = ST_NULL;
            end else if (exhausted) begin
               rsp_status_in = ST_EXHAUSTED;
            end else begin
               bp_in         = end_addr[ADDR_W-1:0];
               rsp_addr_in   = start_ff[ADDR_W-1:0];
               rsp_status_in = ST_OK;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         bp_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bp_ff        <= HEAP_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bp_ff        <= bp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bytes_ff      <= bytes_in;
      pages_ff      <= pages_in;
      freed_ff      <= freed_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      null_ff       <= null_in;
      use_stack_ff  <= use_stack_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   bpfa_free_stack u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stack_ctrl),
      .stat     (stack_stat),
      .top_page (top_page)
   );

   assign rsp_channel.valid           = rsp_valid_ff;
   assign rsp_channel.granted_address = rsp_addr_ff;
   assign rsp_channel.status          = rsp_status_ff;

endmodule

>>> tb/sv/tb_bump_and_free_page_allocator.sv
`timescale 1ns / 1ps

module tb_bump_and_free_page_allocator import bpfa_pkg::*; ();

   typedef struct {
      op_type                  op;
      logic [BYTE_COUNT_W-1:0] byte_count;
      logic [PAGE_COUNT_W-1:0] page_count;
      logic [ADDR_W-1:0]       freed_address;
   } alloc_req_type;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      status_type        status;
   } grant_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ADDR_W-1:0] csr_write_data;

   bpfa_req_if req_if ();
   bpfa_rsp_if rsp_if ();

   bump_and_free_page_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Expected behavior of the allocator.
   logic [ADDR_W-1:0]     model_bump_ptr;
   logic [PAGE_NUM_W-1:0] freed_pages [FREE_STACK_DEPTH];
   int unsigned           freed_depth;

   alloc_req_type pending_reqs [$];
   grant_type     expected_grants [$];
   alloc_req_type next_req;

   bit req_taken;
   bit gaps_off;
   bit hold_done;
   int hold_left;
   int mismatch_count;
   int results_checked;
   int items_queued;
   int base_loads;
   int status_hits [4];

   // Generator's own view of the free stack depth, used only to shape stimulus.
   int shadow_level;
   int full_pushes;

   always #6 clock = ~clock;

   // Rounds the heap pointer up to unit and takes len bytes, unless that runs
   // past the top of the address space.
   task automatic carve(input logic [63:0] unit, input logic [63:0] len, output grant_type g);
      logic [63:0] start_addr;
      logic [63:0] end_addr;
      start_addr = ({32'd0, model_bump_ptr} + unit - 64'd1) & ~(unit - 64'd1);
      end_addr   = start_addr + len;
      if (end_addr > 64'hFFFF_FFFF) begin
         g.addr   = '0;
         g.status = ST_EXHAUSTED;
      end else begin
         model_bump_ptr = end_addr[ADDR_W-1:0];
         g.addr         = start_addr[ADDR_W-1:0];
         g.status       = ST_OK;
      end
   endtask

   task automatic grant_request(input alloc_req_type r, output grant_type g);
      g.addr   = '0;
      g.status = ST_NULL;
      case (r.op)
         OP_BYTE_ALLOC: begin
            if (r.byte_count != 0)
               carve(64'(WORD_ALIGN), 64'(r.byte_count), g);
         end
         OP_PAGE_RUN: begin
            if (r.page_count != 0)
               carve(64'd1 << PAGE_SHIFT, 64'(r.page_count) << PAGE_SHIFT, g);
         end
         OP_FREE_PAGE: begin
            if (freed_depth >= FREE_STACK_DEPTH) begin
               g.status = ST_STACK_FULL;
            end else begin
               freed_pages[freed_depth] = PAGE_NUM_W'(r.freed_address >> PAGE_SHIFT);
               freed_depth++;
               g.status = ST_OK;
            end
         end
         default: begin
            if (freed_depth > 0) begin
               freed_depth--;
               g.addr   = ADDR_W'(freed_pages[freed_depth]) << PAGE_SHIFT;
               g.status = ST_OK;
            end else begin
               carve(64'd1 << PAGE_SHIFT, 64'd1 << PAGE_SHIFT, g);
            end
         end
      endcase
   endtask

   task automatic push_item(input alloc_req_type item);
      if (item.op == OP_FREE_PAGE) begin
         if (shadow_level < FREE_STACK_DEPTH)
            shadow_level++;
         else
            full_pushes++;
      end else if (item.op == OP_ALLOC_PAGE && shadow_level > 0) begin
         shadow_level--;
      end
      pending_reqs.push_back(item);
      items_queued++;
   endtask

   task automatic queue_item(input op_type op, input logic [31:0] bytes,
                             input logic [19:0] pages, input logic [31:0] freed);
      alloc_req_type item;
      item.op            = op;
      item.byte_count    = bytes;
      item.page_count    = pages;
      item.freed_address = freed;
      push_item(item);
   endtask

   // Mostly small sizes so that the heap lasts; huge_pct percent of the items
   // keep fully random sizes. Fields that the operation ignores stay random.
   task automatic queue_random(input int count, input int free_pct, input int pop_pct,
                               input int huge_pct);
      alloc_req_type item;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick               = $urandom_range(99);
         item.byte_count    = $urandom();
         item.page_count    = PAGE_COUNT_W'($urandom());
         item.freed_address = $urandom();
         if (pick < free_pct)
            item.op = OP_FREE_PAGE;
         else if (pick < free_pct + pop_pct)
            item.op = OP_ALLOC_PAGE;
         else if (pick[0])
            item.op = OP_BYTE_ALLOC;
         else
            item.op = OP_PAGE_RUN;
         if ($urandom_range(99) >= huge_pct) begin
            item.byte_count = ($urandom_range(19) == 0) ? '0 : 32'($urandom_range(1, 300));
            item.page_count = ($urandom_range(19) == 0) ? '0 : 20'($urandom_range(1, 8));
         end
         push_item(item);
      end
   endtask

   task automatic settle();
      while (results_checked != items_queued)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic load_heap_base(input logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      base_loads++;
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_reqs.size() != 0 && (gaps_off || $urandom_range(99) >= 21)) begin
            next_req = pending_reqs.pop_front();
            req_if.valid         <= 1'b1;
            req_if.operation     <= next_req.op;
            req_if.byte_count    <= next_req.byte_count;
            req_if.page_count    <= next_req.page_count;
            req_if.freed_address <= next_req.freed_address;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result acceptance, with one long hold-off so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && results_checked >= 150) begin
         hold_done    <= 1'b1;
         hold_left    <= 300;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= gaps_off || $urandom_range(99) >= 21;
      end
   end

   // Monitor: predicts each accepted item and checks each result.
   always @(posedge clock) begin : check_grants
      alloc_req_type seen;
      grant_type     want;
      if (reset) begin
         model_bump_ptr = HEAP_BASE_RESET;
         freed_depth    = 0;
         req_taken      = 1'b0;
         expected_grants.delete();
      end else begin
         if (csr_write_enable)
            model_bump_ptr = csr_write_data;
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (expected_grants.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got address %h status %0d",
                        $time, rsp_if.granted_address, rsp_if.status);
            end else begin
               want = expected_grants.pop_front();
               status_hits[want.status]++;
               if (rsp_if.granted_address !== want.addr) begin
                  mismatch_count++;
                  $display("%0t: granted_address expected %h, got %h",
                           $time, want.addr, rsp_if.granted_address);
               end
               if (rsp_if.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_if.status);
               end
            end
         end
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) begin
            seen.op            = op_type'(req_if.operation);
            seen.byte_count    = req_if.byte_count;
            seen.page_count    = req_if.page_count;
            seen.freed_address = req_if.freed_address;
            grant_request(seen, want);
            expected_grants.push_back(want);
         end
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_if.valid         = 1'b0;
      req_if.operation     = OP_BYTE_ALLOC;
      req_if.byte_count    = '0;
      req_if.page_count    = '0;
      req_if.freed_address = '0;
      rsp_if.ready         = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed checks against the reset heap base.
      queue_item(OP_BYTE_ALLOC, 32'd0, 20'd5, 32'hFFFF_FFFF);
      queue_item(OP_BYTE_ALLOC, 32'd1, 20'd0, 32'd0);
      queue_item(OP_BYTE_ALLOC, 32'd5, 20'd0, 32'd0);
      queue_item(OP_PAGE_RUN, 32'd9, 20'd0, 32'd0);
      queue_item(OP_PAGE_RUN, 32'd0, 20'd1, 32'd0);
      queue_item(OP_PAGE_RUN, 32'd0, 20'hF_FFFF, 32'd0);
      queue_item(OP_BYTE_ALLOC, 32'hFFFF_FFFF, 20'd0, 32'd0);
      queue_item(OP_ALLOC_PAGE, 32'd0, 20'd0, 32'd0);
      queue_item(OP_FREE_PAGE, 32'd0, 20'd0, 32'h0000_0000);
      queue_item(OP_FREE_PAGE, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
      queue_item(OP_FREE_PAGE, 32'd0, 20'd0, 32'h1234_5ABC);
      queue_item(OP_ALLOC_PAGE, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
      queue_item(OP_ALLOC_PAGE, 32'd0, 20'd0, 32'd0);
      queue_item(OP_ALLOC_PAGE, 32'd0, 20'd0, 32'd0);
      queue_item(OP_ALLOC_PAGE, 32'd0, 20'd0, 32'd0);
      queue_item(OP_BYTE_ALLOC, 32'd3, 20'd0, 32'd0);
      queue_item(OP_PAGE_RUN, 32'd0, 20'd3, 32'd0);
      settle();

      // The first byte grant fits; after it the rounded pointer alone overflows.
      load_heap_base(32'hFFFF_FFFC);
      queue_item(OP_BYTE_ALLOC, 32'd1, 20'd0, 32'd0);
      queue_item(OP_BYTE_ALLOC, 32'd3, 20'd0, 32'd0);
      queue_item(OP_PAGE_RUN, 32'd0, 20'd1, 32'd0);
      queue_item(OP_ALLOC_PAGE, 32'd0, 20'd0, 32'd0);
      settle();

      load_heap_base(32'h0000_0000);
      queue_random(250, 20, 20, 3);
      settle();

      load_heap_base(32'hFFFF_FFFF);
      queue_random(80, 25, 25, 5);
      settle();

      gaps_off = 1'b1;
      load_heap_base(32'hFFFC_0000 | 32'($urandom_range(0, 32'hFFF)));
      queue_random(200, 15, 15, 10);
      settle();
      gaps_off = 1'b0;

      // Push until the free stack overflows a number of times.
      load_heap_base($urandom());
      while (shadow_level < FREE_STACK_DEPTH || full_pushes < 12)
         queue_random(1, 92, 4, 2);
      settle();

      load_heap_base(32'h0000_1000);
      queue_random(200, 10, 60, 3);
      settle();

      if (expected_grants.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d results expected, none left to come",
                  $time, expected_grants.size());
      end
      $display("Checked %0d results for %0d requests over %0d heap base settings.",
               results_checked, items_queued, base_loads + 1);
      $display("Outcomes: %0d ok, %0d null, %0d exhausted, %0d free stack full.",
               status_hits[ST_OK], status_hits[ST_NULL], status_hits[ST_EXHAUSTED],
               status_hits[ST_STACK_FULL]);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: run timed out", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_req_if.sv
rtl/core/bpfa_ram.sv
rtl/core/bpfa_free_stack.sv
rtl/core/bump_and_free_page_allocator.sv
tb/sv/tb_bump_and_free_page_allocator.sv
